/* rtl/video_sector_frame_demux_top_macros.svh */
// Assertion macros for the video sector frame demux.
`ifndef VIDEO_SECTOR_FRAME_DEMUX_TOP_MACROS_SVH
`define VIDEO_SECTOR_FRAME_DEMUX_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define VSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define VSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vsfd_pkg.sv */
// Types and constants shared by the video sector frame demux.
package vsfd_pkg;

  localparam logic [15:0] MAGIC_OK        = 16'h0160;
  localparam logic [15:0] TYPE_VIDEO      = 16'h8001;
  localparam logic [15:0] ROUND_MASK      = 16'hfff0;
  localparam logic [15:0] ROUND_ADD       = 16'd15;
  localparam logic [12:0] WORDS_PER_CHUNK = 13'd504;
  localparam logic [16:0] REM_FLOOR       = 17'h10000;
  localparam logic [15:0] DROP_MAX        = 16'hffff;
  localparam logic [31:0] FRAME_RESET     = 32'hffff_ffff;

  typedef enum logic [1:0] {
    ST_APPEND = 2'd0,
    ST_IGNORE = 2'd1,
    ST_END    = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0]        magic_word;
    logic [15:0]        sector_type;
    logic [15:0]        chunk_number;
    logic [15:0]        chunk_total;
    logic signed [31:0] frame_number;
    logic [15:0]        pixel_width;
    logic [15:0]        pixel_height;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic        frame_complete;
    logic        frame_dropped;
    logic        buffer_index;
    logic [12:0] word_offset;
    logic [15:0] rounded_width;
    logic [15:0] rounded_height;
    logic [15:0] dropped_total;
  } out_t;

  // Handshake status of the input register toward the core and output stage.
  typedef struct packed {
    logic valid;
    logic fire;
  } stage_ctl_t;

endpackage

/* rtl/video_sector_frame_demux_top.sv */
// Top level of the video sector frame demux: input register, decision core, result register.
// The only stages are the input and result registers, with the decision core between them.
// Throughput: one request per cycle while out_stall is low.
// Reset: synchronous active-low rst_n clears both valid flags and the frame state
// (current frame -1, no chunks pending, buffer 0, no drops, stream open).
`include "video_sector_frame_demux_top_macros.svh"

module video_sector_frame_demux_top #(
  parameter int MAX_CHUNKS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vsfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vsfd_pkg::out_t out_data
);

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  vsfd_pkg::out_t       out_data_r;
  logic                 take_ok;
  vsfd_pkg::stage_ctl_t ctl;
  vsfd_pkg::in_t        req;
  vsfd_pkg::out_t       res;
  logic                 ended;

  assign take_ok   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  vsfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take_ok  (take_ok),
    .ctl      (ctl),
    .req      (req)
  );

  vsfd_core #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (ctl.fire),
    .req   (req),
    .res   (res),
    .ended (ended)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      out_data_r <= res;
    end
  end

  `VSFD_ASSERT_NOW(a_ended_sticky, ctl.fire && ended, res.status == vsfd_pkg::ST_END && !res.frame_complete && !res.frame_dropped, "ended stream gave a non-end result")
  `VSFD_ASSERT_NEXT(a_fire_loads_out, ctl.fire, out_valid_r, "request moved on but no result is held")
  `VSFD_ASSERT_NOW(a_stall_only_when_full, in_stall, ctl.valid && out_valid_r, "input stalled with room in the pipeline")

endmodule

/* rtl/vsfd_in_stage.sv */
// Input request register with stall toward the upstream side.
module vsfd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vsfd_pkg::in_t       in_data,
  input  logic                take_ok,
  output vsfd_pkg::stage_ctl_t ctl,
  output vsfd_pkg::in_t       req
);

  logic          valid_r;
  logic          valid_nxt;
  logic          load;
  vsfd_pkg::in_t req_r;

  assign in_stall  = valid_r && !take_ok;
  assign load      = in_valid && !in_stall;
  assign ctl.valid = valid_r;
  assign ctl.fire  = valid_r && take_ok;
  assign req       = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (ctl.fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_data;
    end
  end

endmodule

/* rtl/vsfd_core.sv */
// Frame tracking state and per-sector decision logic.
module vsfd_core #(
  parameter int MAX_CHUNKS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  vsfd_pkg::in_t  req,
  output vsfd_pkg::out_t res,
  output logic           ended
);

  logic signed [31:0] frame_r, frame_nxt;
  logic [16:0]        rem_r, rem_nxt;
  logic               wbuf_r, wbuf_nxt;
  logic [15:0]        drop_r, drop_nxt;
  logic               ended_r, ended_nxt;
  logic [15:0]        width_r, width_nxt;
  logic [15:0]        height_r, height_nxt;
  logic [16:0]        rem_base;
  logic               newer;

  assign ended = ended_r;
  assign newer = req.frame_number > frame_r;

  always_comb begin
    frame_nxt  = frame_r;
    rem_nxt    = rem_r;
    wbuf_nxt   = wbuf_r;
    drop_nxt   = drop_r;
    ended_nxt  = ended_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    rem_base   = rem_r;
    res.status         = vsfd_pkg::ST_END;
    res.frame_complete = 1'b0;
    res.frame_dropped  = 1'b0;
    res.word_offset    = '0;

    if (ended_r || req.magic_word != vsfd_pkg::MAGIC_OK) begin
      ended_nxt  = 1'b1;
      res.status = vsfd_pkg::ST_END;
    end else if (req.sector_type != vsfd_pkg::TYPE_VIDEO) begin
      res.status = vsfd_pkg::ST_IGNORE;
    end else if (req.frame_number < frame_r) begin
      ended_nxt  = 1'b1;
      res.status = vsfd_pkg::ST_END;
    end else begin
      if (newer) begin
        if (rem_r != '0) begin
          res.frame_dropped = 1'b1;
          if (drop_r != vsfd_pkg::DROP_MAX) begin
            drop_nxt = drop_r + 16'd1;
          end
        end else begin
          res.frame_complete = 1'b1;
        end
        frame_nxt  = req.frame_number;
        rem_base   = {1'b0, req.chunk_total};
        wbuf_nxt   = !wbuf_r;
        width_nxt  = (req.pixel_width + vsfd_pkg::ROUND_ADD) & vsfd_pkg::ROUND_MASK;
        height_nxt = (req.pixel_height + vsfd_pkg::ROUND_ADD) & vsfd_pkg::ROUND_MASK;
      end
      rem_nxt = rem_base;
      if (rem_base != vsfd_pkg::REM_FLOOR) begin
        rem_nxt = rem_base - 17'd1;
      end
      if (req.chunk_number >= 16'(MAX_CHUNKS)) begin
        res.status = vsfd_pkg::ST_RANGE;
      end else begin
        res.status      = vsfd_pkg::ST_APPEND;
        res.word_offset = req.chunk_number[12:0] * vsfd_pkg::WORDS_PER_CHUNK;
      end
    end

    res.buffer_index   = wbuf_nxt;
    res.rounded_width  = width_nxt;
    res.rounded_height = height_nxt;
    res.dropped_total  = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= vsfd_pkg::FRAME_RESET;
      rem_r    <= '0;
      wbuf_r   <= 1'b0;
      drop_r   <= '0;
      ended_r  <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
    end else if (fire) begin
      frame_r  <= frame_nxt;
      rem_r    <= rem_nxt;
      wbuf_r   <= wbuf_nxt;
      drop_r   <= drop_nxt;
      ended_r  <= ended_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for video_sector_frame_demux_top: directed and random sector headers.
`timescale 1ns / 1ps

module tb_top;

  localparam int CHUNK_LIMIT = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int STREAM_ITEMS = 405;
  localparam int NOISE_ITEMS = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vsfd_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vsfd_pkg::out_t out_data;

  video_sector_frame_demux_top #(.MAX_CHUNKS(CHUNK_LIMIT)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Demux state as the block should hold it
  logic signed [31:0] open_frame = vsfd_pkg::FRAME_RESET;
  logic [16:0]        chunks_left = '0;
  logic               wbuf = 1'b0;
  logic [15:0]        drop_cnt = '0;
  logic               ended = 1'b0;
  logic [15:0]        lat_w = '0;
  logic [15:0]        lat_h = '0;

  vsfd_pkg::in_t  sector_q[$];
  bit             pause_q[$];
  vsfd_pkg::out_t due_results[$];
  bit             hold_next = 1'b0;

  int          errors = 0;
  int          idle_cycles = 0;
  logic        in_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm = 0;

  function automatic vsfd_pkg::out_t predict_sector(vsfd_pkg::in_t s);
    vsfd_pkg::out_t r;
    r = '0;
    r.status = vsfd_pkg::ST_APPEND;
    if (ended || s.magic_word != vsfd_pkg::MAGIC_OK) begin
      ended = 1'b1;
      r.status = vsfd_pkg::ST_END;
    end else if (s.sector_type != vsfd_pkg::TYPE_VIDEO) begin
      r.status = vsfd_pkg::ST_IGNORE;
    end else if (s.frame_number < open_frame) begin
      ended = 1'b1;
      r.status = vsfd_pkg::ST_END;
    end else begin
      if (s.frame_number > open_frame) begin
        if (chunks_left != '0) begin
          r.frame_dropped = 1'b1;
          if (drop_cnt != vsfd_pkg::DROP_MAX) drop_cnt = drop_cnt + 16'd1;
        end else begin
          r.frame_complete = 1'b1;
        end
        open_frame = s.frame_number;
        chunks_left = {1'b0, s.chunk_total};
        wbuf = ~wbuf;
        lat_w = (s.pixel_width + vsfd_pkg::ROUND_ADD) & vsfd_pkg::ROUND_MASK;
        lat_h = (s.pixel_height + vsfd_pkg::ROUND_ADD) & vsfd_pkg::ROUND_MASK;
      end
      if (chunks_left != vsfd_pkg::REM_FLOOR) chunks_left = chunks_left - 17'd1;
      if (s.chunk_number >= CHUNK_LIMIT) begin
        r.status = vsfd_pkg::ST_RANGE;
      end else begin
        r.word_offset = vsfd_pkg::WORDS_PER_CHUNK * s.chunk_number[12:0];
      end
    end
    r.buffer_index = wbuf;
    r.rounded_width = lat_w;
    r.rounded_height = lat_h;
    r.dropped_total = drop_cnt;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [15:0] pick_dim();
    logic [15:0] edges[8];
    edges = '{16'd0, 16'd1, 16'd15, 16'd16, 16'd17, 16'd65520, 16'd65521, 16'd65535};
    if ($urandom_range(0, 5) == 0) return edges[$urandom_range(0, 7)];
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [15:0] other_type();
    logic [15:0] t;
    t = $urandom_range(0, 65535);
    if (t == vsfd_pkg::TYPE_VIDEO) t = ~t;
    return t;
  endfunction

  task automatic add_sector(logic [15:0] magic, logic [15:0] stype, logic [15:0] chunk,
                            logic [15:0] total, logic [31:0] frame, logic [15:0] w,
                            logic [15:0] h);
    vsfd_pkg::in_t s;
    s.magic_word = magic;
    s.sector_type = stype;
    s.chunk_number = chunk;
    s.chunk_total = total;
    s.frame_number = frame;
    s.pixel_width = w;
    s.pixel_height = h;
    sector_q.push_back(s);
    pause_q.push_back(hold_next);
    hold_next = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Request driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (sector_q.size() > 0 && (!pause_q[0] || due_results.size() == 0)) begin
          in_data <= sector_q.pop_front();
          void'(pause_q.pop_front());
          in_valid <= 1'b1;
          in_gap <= (in_calm > 0) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (in_calm > 0) in_calm <= in_calm - 1;
      else if ($urandom_range(0, 59) == 0) in_calm <= $urandom_range(20, 80);
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= (out_calm > 0) ? 0 : idle_len();
    end
    if (out_calm > 0) out_calm <= out_calm - 1;
    else if ($urandom_range(0, 59) == 0) out_calm <= $urandom_range(20, 80);
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin
    vsfd_pkg::out_t want;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) due_results.push_back(predict_sector(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("frame_complete", want.frame_complete, out_data.frame_complete);
          check_field("frame_dropped", want.frame_dropped, out_data.frame_dropped);
          check_field("buffer_index", want.buffer_index, out_data.buffer_index);
          check_field("word_offset", want.word_offset, out_data.word_offset);
          check_field("rounded_width", want.rounded_width, out_data.rounded_width);
          check_field("rounded_height", want.rounded_height, out_data.rounded_height);
          check_field("dropped_total", want.dropped_total, out_data.dropped_total);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    longint      frame_no;
    longint      nxt;
    logic [15:0] total;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] older;
    int          n;
    int          r;

    // Directed: first frame, full and partial frames, extra chunks, range, ignored types
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd0, 16'd2, 32'd0, 16'd1, 16'd65535);
    add_sector(vsfd_pkg::MAGIC_OK, 16'h0000, 16'd0, 16'd2, 32'd0, 16'd0, 16'd0);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd1, 16'd2, 32'd0, 16'd1, 16'd65535);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd15, 16'd3, 32'd1, 16'd65521,
               16'd16);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd16, 16'd3, 32'd1, 16'd65521,
               16'd16);
    add_sector(vsfd_pkg::MAGIC_OK, 16'hffff, 16'd1, 16'd3, 32'd1, 16'd0, 16'd0);
    add_sector(vsfd_pkg::MAGIC_OK, 16'h8000, 16'd1, 16'd3, 32'd1, 16'd0, 16'd0);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd0, 16'd0, 32'd3, 16'd0, 16'd0);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd1, 16'd0, 32'd3, 16'd0, 16'd0);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd0, 16'd1, 32'd4, 16'd65535,
               16'd17);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'hffff, 16'd1, 32'd4, 16'd65535,
               16'd17);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd2, 16'd1, 32'd4, 16'd65535,
               16'd17);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd0, 16'd16, 32'd5, 16'd15,
               16'd65520);
    add_sector(vsfd_pkg::MAGIC_OK, 16'h0001, 16'd3, 16'd16, 32'd5, 16'd15, 16'd65520);
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd8, 16'd16, 32'd5, 16'd15,
               16'd65520);

    // Random well-formed frames with missing, duplicate and out-of-range chunks
    hold_next = 1'b1;
    frame_no = 5;
    while (sector_q.size() < STREAM_ITEMS) begin
      if ($urandom_range(0, 14) == 0) nxt = frame_no + $urandom_range(1, 1 << 26);
      else nxt = frame_no + $urandom_range(1, 3);
      if (nxt > 64'sh7fffffff) nxt = 64'sh7fffffff;
      frame_no = nxt;
      case ($urandom_range(0, 11))
        0: total = 16'd0;
        1: total = $urandom_range(0, 65535);
        default: total = $urandom_range(1, CHUNK_LIMIT);
      endcase
      w = pick_dim();
      h = pick_dim();
      n = (total > CHUNK_LIMIT) ? $urandom_range(1, CHUNK_LIMIT) : total;
      if (n == 0) n = 1;
      for (int c = 0; c < n; c++) begin
        r = $urandom_range(0, 99);
        if (r < 8) continue;
        if (r < 14) add_sector(vsfd_pkg::MAGIC_OK, other_type(), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom(), pick_dim(), pick_dim());
        if (r >= 14 && r < 19)
          add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO,
                     $urandom_range(CHUNK_LIMIT, 65535), total, frame_no, w, h);
        else
          add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, c, total, frame_no, w, h);
        if (r >= 94)
          add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, c, total, frame_no, w, h);
      end
    end

    // Highest frame number, then end the stream
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd0, 16'd2, 32'h7fffffff,
               pick_dim(), pick_dim());
    add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd1, 16'd2, 32'h7fffffff,
               pick_dim(), pick_dim());
    hold_next = 1'b1;
    if ($urandom_range(0, 1) == 0) begin
      w = $urandom_range(0, 65535);
      if (w == vsfd_pkg::MAGIC_OK) w = ~w;
      add_sector(w, vsfd_pkg::TYPE_VIDEO, 16'd0, 16'd1, 32'h7fffffff, pick_dim(), pick_dim());
    end else begin
      older = $urandom();
      if (older == 32'h7fffffff) older = 32'd0;
      add_sector(vsfd_pkg::MAGIC_OK, vsfd_pkg::TYPE_VIDEO, 16'd0, 16'd1, older, pick_dim(),
                 pick_dim());
    end

    // After the end: anything, including well-formed sectors, stays ended
    for (int i = 0; i < NOISE_ITEMS; i++) begin
      add_sector(($urandom_range(0, 3) == 0) ? vsfd_pkg::MAGIC_OK
                                             : 16'($urandom_range(0, 65535)),
                 ($urandom_range(0, 1) == 0) ? vsfd_pkg::TYPE_VIDEO : other_type(),
                 $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom(),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (sector_q.size() > 0 || in_valid || due_results.size() > 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
